[rtl/mbl_pkg.sv]
// Shared types and constants for the MAC blocklist table.
`timescale 1ns / 1ps

package mbl_pkg;

   localparam int MAC_W         = 48;
   localparam int CMD_W         = 2;
   localparam int ENTRY_COUNT_W = 5;

   // Command codes; the fourth code behaves as a lookup
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic match;
      logic commit;
   } ctrl_cmd_type;

endpackage

[rtl/mbl_req_if.sv]
// Request channel: command and MAC with valid/ready handshake.
`timescale 1ns / 1ps

interface mbl_req_if;
   logic                              valid;
   logic                              ready;
   logic [mbl_pkg::CMD_W-1:0]         cmd;
   logic [mbl_pkg::MAC_W-1:0]         mac;

   modport source (output valid, output cmd, output mac, input ready);
   modport sink   (input valid, input cmd, input mac, output ready);
endinterface

[rtl/mbl_rsp_if.sv]
// Response channel: hit, eviction flag and entry count with valid/ready handshake.
`timescale 1ns / 1ps

interface mbl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  hit;
   logic                                  evicted;
   logic [mbl_pkg::ENTRY_COUNT_W-1:0]     entry_count;

   modport source (output valid, output hit, output evicted, output entry_count, input ready);
   modport sink   (input valid, input hit, input evicted, input entry_count, output ready);
endinterface

[rtl/mbl_ctrl.sv]
// Sequencing state machine and response valid flag for the MAC blocklist table.
`timescale 1ns / 1ps

module mbl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mbl_pkg::ctrl_cmd_type cmd
);

   mbl_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Output slot can take a new result when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbl_pkg::ST_IDLE: begin
            if (req_valid) state_in = mbl_pkg::ST_MATCH;
         end
         mbl_pkg::ST_MATCH: begin
            state_in = mbl_pkg::ST_COMMIT;
         end
         mbl_pkg::ST_COMMIT: begin
            if (out_free) state_in = mbl_pkg::ST_IDLE;
         end
         default: begin
            state_in = mbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.match  = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         mbl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         mbl_pkg::ST_MATCH: begin
            cmd.match = 1'b1;
         end
         mbl_pkg::ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/mbl_datapath.sv]
// Entry list, per-entry comparators, shift logic and result register.
`timescale 1ns / 1ps

module mbl_datapath #(
   parameter int LIST_DEPTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mbl_pkg::ctrl_cmd_type               cmd,
   input  logic [mbl_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mbl_pkg::MAC_W-1:0]           req_mac,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic [mbl_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count
);

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int STEPS  = $clog2(LIST_DEPTH);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

   logic [mbl_pkg::CMD_W-1:0]       cmd_ff;
   logic [mbl_pkg::MAC_W-1:0]       mac_ff;
   logic [mbl_pkg::MAC_W-1:0]       entry_ff [LIST_DEPTH];
   logic [mbl_pkg::MAC_W-1:0]       entry_in [LIST_DEPTH];
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [LIST_DEPTH-1:0]           match_ff, match_in;
   logic [LIST_DEPTH-1:0]           prefix;
   logic                            hit, full, evicted;
   logic                            hit_ff, evicted_ff;
   logic [mbl_pkg::ENTRY_COUNT_W-1:0] entry_count_ff;

   // Compare every occupied lane against the request MAC
   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         match_in[i] = (entry_ff[i] == mac_ff) && (CNT_W'(i) < count_ff);
      end
   end

   always_comb begin
      // Mark the matching lane and every lane above it: those take their upper neighbour
      prefix = match_ff;
      for (int k = 0; k < STEPS; k++) begin
         prefix = prefix | (prefix << (1 << k));
      end

      hit      = |match_ff;
      full     = (count_ff == FULL_CNT);
      evicted  = 1'b0;
      count_in = count_ff;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end

      case (cmd_ff)
         mbl_pkg::CMD_ADD: begin
            if (!hit) begin
               if (full) begin
                  // Drop the oldest, append at the top
                  for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                     entry_in[i] = entry_ff[i + 1];
                  end
                  entry_in[LIST_DEPTH-1] = mac_ff;
                  evicted                = 1'b1;
               end else begin
                  for (int i = 0; i < LIST_DEPTH; i++) begin
                     if (count_ff == CNT_W'(i)) entry_in[i] = mac_ff;
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         mbl_pkg::CMD_REMOVE: begin
            if (hit) begin
               for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                  if (prefix[i]) entry_in[i] = entry_ff[i + 1];
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         mac_ff <= req_mac;
      end
      if (cmd.match) begin
         match_ff <= match_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < LIST_DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
         hit_ff         <= hit;
         evicted_ff     <= evicted;
         entry_count_ff <= mbl_pkg::ENTRY_COUNT_W'(count_in);
      end
   end

   assign rsp_hit         = hit_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_entry_count = entry_count_ff;

endmodule

[rtl/mac_blocklist_fifo_table_top.sv]
// Top level of the MAC address blocklist table.
`timescale 1ns / 1ps

// An ordered list of up to LIST_DEPTH 48-bit MAC addresses, oldest first. Each request
// (lookup, add, remove) returns one response with hit, eviction flag and the new entry
// count. An item passes through accept, a match step in which every lane compares its
// entry against the MAC in parallel, and a commit step in which the list shifts or
// appends and the response register loads. The commit waits while the previous response
// has not yet been transferred; a new request is accepted while a response is pending.
// One request is in flight at a time. No initialisation pass is needed after reset.
module mac_blocklist_fifo_table_top #(
   parameter int LIST_DEPTH = 20
) (
   input  logic         clock,
   input  logic         reset,
   mbl_req_if.sink      req_ch,
   mbl_rsp_if.source    rsp_ch
);

   mbl_pkg::ctrl_cmd_type ctrl_cmd;

   mbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (ctrl_cmd)
   );

   mbl_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .req_cmd         (req_ch.cmd),
      .req_mac         (req_ch.mac),
      .rsp_hit         (rsp_ch.hit),
      .rsp_evicted     (rsp_ch.evicted),
      .rsp_entry_count (rsp_ch.entry_count)
   );

endmodule

[rtl/mbl_checker.sv]
// Port-level checks for the MAC blocklist table, bound to the top level.
`timescale 1ns / 1ps

module mbl_checker #(
   parameter int LIST_DEPTH = 20
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_hit,
   input logic                                rsp_evicted,
   input logic [mbl_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count
);

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted)
         && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // One request in flight: no accept straight after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // Eviction only on a miss into a full list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit
         && (rsp_entry_count == mbl_pkg::ENTRY_COUNT_W'(LIST_DEPTH)))
      else $error("eviction reported without a full-list miss");

   // Count never beyond the depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (LIST_DEPTH > 31) || (32'(rsp_entry_count) <= LIST_DEPTH))
      else $error("entry count beyond list depth");

endmodule

bind mac_blocklist_fifo_table_top mbl_checker #(
   .LIST_DEPTH (LIST_DEPTH)
) u_mbl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_hit         (rsp_ch.hit),
   .rsp_evicted     (rsp_ch.evicted),
   .rsp_entry_count (rsp_ch.entry_count)
);
